FILE: hdl/sine_cosine_taylor_series_top_defines.svh
// Assertion helpers shared by the block's modules.
// They expect clk and rst_n to be visible where they are used.
`ifndef SINE_COSINE_TAYLOR_SERIES_TOP_DEFINES_SVH
`define SINE_COSINE_TAYLOR_SERIES_TOP_DEFINES_SVH

// Same-cycle implication.
`define SCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sct_pkg.sv
package sct_pkg;

  localparam int MAX_TERMS_DEF = 16;

  // Q formats
  localparam int ANGLE_W    = 31;
  localparam int ABS_W      = 30;
  localparam int VALUE_W    = 32;
  localparam int FRAC_SHIFT = 28;
  localparam int RND_BIT    = 27;

  // Term magnitude stays below about 5.2 in Q.30, x^2 below 10 in Q.28.
  localparam int MAG_W  = 33;
  localparam int X2_W   = 32;
  localparam int PROD_W = MAG_W + X2_W;
  localparam int NUM_W  = PROD_W + 1 - FRAC_SHIFT;
  localparam int SUM_W  = 35;

  // Quotient bits resolved per divider cycle.
  localparam int DIV_RADIX_BITS = 2;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 31'sd843314857;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -31'sd843314857;
  localparam logic [MAG_W-1:0]          Q30_ONE   = MAG_W'(64'd1 << 30);
  localparam logic signed [SUM_W-1:0]   SUM_MAX   = SUM_W'(64'sd1073741824);
  localparam logic signed [SUM_W-1:0]   SUM_MIN   = -SUM_W'(64'sd1073741824);

  localparam logic CMD_SINE   = 1'b0;
  localparam logic CMD_COSINE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_INIT,
    ST_MUL,
    ST_DIVST,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: hdl/sct_div.sv
`include "sine_cosine_taylor_series_top_defines.svh"

module sct_div #(
  parameter int D_W = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sct_pkg::NUM_W-1:0] dividend,
  input  logic [D_W-1:0]            divisor,
  output logic [sct_pkg::NUM_W-1:0] quotient,
  output sct_pkg::div_sts_t         sts
);
  import sct_pkg::*;

  localparam int STEPS = (NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int PAD_W = STEPS * DIV_RADIX_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0] quo_r, quo_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   divisor_r, divisor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  // Restoring long division, a few quotient bits per cycle.
  always_comb begin
    logic [PAD_W-1:0] q;
    logic [D_W-1:0]   rm;
    logic [D_W:0]     t;
    q           = quo_r;
    rm          = rem_r;
    t           = '0;
    divisor_nxt = divisor_r;
    cnt_nxt     = cnt_r;
    done_nxt    = 1'b0;
    if (start) begin
      q           = PAD_W'(dividend);
      rm          = '0;
      divisor_nxt = divisor;
      cnt_nxt     = CNT_W'(STEPS);
    end else if (cnt_r != '0) begin
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
        t = {rm, q[PAD_W-1]};
        q = {q[PAD_W-2:0], 1'b0};
        if (t >= {1'b0, divisor_r}) begin
          t    = t - {1'b0, divisor_r};
          q[0] = 1'b1;
        end
        rm = t[D_W-1:0];
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
    quo_nxt = q;
    rem_nxt = rm;
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r[NUM_W-1:0];
  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;

  `SCT_ASSERT_NOW(a_start_idle, start, cnt_r == '0, "divider started while busy")
  `SCT_ASSERT_NEXT(a_start_busy, start, cnt_r != '0, "divider did not begin after start")
  `SCT_ASSERT_NOW(a_rem_lt_div, done_r, rem_r < divisor_r, "remainder not below divisor")

endmodule

FILE: hdl/sine_cosine_taylor_series_top.sv
// Sine or cosine of an angle by Maclaurin series. An item carries in_cmd (0 sine,
// 1 cosine) and in_angle (signed Q3.28 radians, clamped to [-pi, pi]); the result
// out_value is signed Q2.30, saturated to [-1, 1]. One shared multiplier forms x^2
// and then each term times x^2; an iterative divider (two quotient bits a cycle)
// divides by n(n+1). An item runs through T terms past the first, at most
// MAX_TERMS-1, ending at the first term that rounds to zero. One item is in work
// at a time; in_ready is high only between items, and a finished result waits in
// the output register while the next item is accepted.
`include "sine_cosine_taylor_series_top_defines.svh"

module sine_cosine_taylor_series_top #(
  parameter int MAX_TERMS = sct_pkg::MAX_TERMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic signed [sct_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sct_pkg::VALUE_W-1:0] out_value
);
  import sct_pkg::*;

  localparam int K_W = $clog2(MAX_TERMS);
  localparam int N_W = K_W + 1;
  localparam int D_W = $clog2(2 * (MAX_TERMS - 1) * (2 * MAX_TERMS - 1) + 1);
  localparam logic [K_W-1:0] K_LAST = K_W'(MAX_TERMS - 1);

  state_t state_r, state_nxt;

  logic                    cos_r, cos_nxt;
  logic                    neg_r, neg_nxt;
  logic [ABS_W-1:0]        a_r, a_nxt;
  logic [X2_W-1:0]         x2_r, x2_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [K_W-1:0]          k_r, k_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;

  logic                    out_free;
  logic                    div_start;
  logic [MAG_W-1:0]        mul_a;
  logic [X2_W-1:0]         mul_b;
  logic [N_W-1:0]          n_val;
  logic [2*N_W-1:0]        d_full;
  logic [D_W-1:0]          d_val;
  logic [PROD_W:0]         num_full;
  logic [NUM_W-1:0]        div_num;
  logic [NUM_W-1:0]        div_quo;
  logic [MAG_W-1:0]        quo_mag;
  div_sts_t                div_sts;

  assign out_free = !out_valid_r || out_ready;

  // n = 2k for sine, 2k-1 for cosine; divisor n(n+1)
  assign n_val    = {k_r, 1'b0} - N_W'(cos_r);
  assign d_full   = (2*N_W)'(n_val) * ((2*N_W)'(n_val) + 1'b1);
  assign d_val    = d_full[D_W-1:0];
  // Fold the half-up rounding into the dividend: floor((p + d*2^27) / (d*2^28)).
  assign num_full = (PROD_W+1)'(prod_r) + ((PROD_W+1)'(d_val) << RND_BIT);
  assign div_num  = num_full[PROD_W:FRAC_SHIFT];
  assign quo_mag  = div_quo[MAG_W-1:0];

  assign mul_a = (state_r == ST_SQR) ? MAG_W'(a_r) : mag_r;
  assign mul_b = (state_r == ST_SQR) ? X2_W'(a_r) : x2_r;

  sct_div #(
    .D_W (D_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (d_val),
    .quotient (div_quo),
    .sts      (div_sts)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SQR;
      ST_SQR:   state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIVST;
      ST_DIVST: state_nxt = ST_DIV;
      ST_DIV:   if (div_sts.done) state_nxt = ST_ACC;
      ST_ACC: begin
        if (quo_mag == '0 || k_r == K_LAST) state_nxt = ST_DONE;
        else state_nxt = ST_MUL;
      end
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    div_start = (state_r == ST_DIVST);
  end

  // Datapath
  always_comb begin
    logic signed [ANGLE_W-1:0] ang_c;
    logic [PROD_W-1:0]         x2_full;
    logic [SUM_W-1:0]          mag_ext;
    ang_c         = in_angle;
    x2_full       = '0;
    mag_ext       = '0;
    cos_nxt       = cos_r;
    neg_nxt       = neg_r;
    a_nxt         = a_r;
    x2_nxt        = x2_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    case (state_r)
      ST_IDLE: begin
        if (in_angle > ANGLE_MAX) ang_c = ANGLE_MAX;
        else if (in_angle < ANGLE_MIN) ang_c = ANGLE_MIN;
        cos_nxt = in_cmd;
        neg_nxt = ang_c[ANGLE_W-1];
        a_nxt   = ang_c[ANGLE_W-1] ? ABS_W'(-ang_c) : ABS_W'(ang_c);
      end
      ST_SQR, ST_MUL: begin
        prod_nxt = mul_a * mul_b;
      end
      ST_INIT: begin
        x2_full = prod_r + PROD_W'(64'd1 << RND_BIT);
        x2_nxt  = x2_full[FRAC_SHIFT +: X2_W];
        k_nxt   = K_W'(1);
        if (cos_r == CMD_COSINE) begin
          mag_nxt = Q30_ONE;
          neg_nxt = 1'b0;
          sum_nxt = SUM_W'(Q30_ONE);
        end else begin
          mag_nxt = MAG_W'({a_r, 2'b00});
          mag_ext = SUM_W'({a_r, 2'b00});
          sum_nxt = neg_r ? -$signed(mag_ext) : $signed(mag_ext);
        end
      end
      ST_ACC: begin
        mag_nxt = quo_mag;
        neg_nxt = !neg_r;
        mag_ext = SUM_W'(quo_mag);
        // flip sign, add unless the term rounded away
        if (quo_mag != '0) begin
          sum_nxt = neg_r ? sum_r + $signed(mag_ext) : sum_r - $signed(mag_ext);
          k_nxt   = k_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sum_r > SUM_MAX) out_value_nxt = VALUE_W'(SUM_MAX);
          else if (sum_r < SUM_MIN) out_value_nxt = VALUE_W'(SUM_MIN);
          else out_value_nxt = VALUE_W'(sum_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cos_r       <= cos_nxt;
    neg_r       <= neg_nxt;
    a_r         <= a_nxt;
    x2_r        <= x2_nxt;
    mag_r       <= mag_nxt;
    prod_r      <= prod_nxt;
    sum_r       <= sum_nxt;
    k_r         <= k_nxt;
    out_value_r <= out_value_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `SCT_ASSERT_NEXT(a_accept_sqr, in_valid && in_ready, state_r == ST_SQR, "accept did not start")
  `SCT_ASSERT_NOW(a_div_done_st, div_sts.done, state_r == ST_DIV, "divider done out of step")
  `SCT_ASSERT_NOW(a_acc_k, state_r == ST_ACC, k_r != '0, "term index zero at accumulate")
  `SCT_ASSERT_NOW(a_out_range, out_valid_r,
    (out_value_r <= 32'sd1073741824) && (out_value_r >= -32'sd1073741824),
    "result outside unit range")

endmodule

FILE: tb/sine_cosine_taylor_series_top_tb.sv
module sine_cosine_taylor_series_top_tb;
  import sct_pkg::*;

  localparam int TERMS          = MAX_TERMS_DEF;
  localparam int SLOWEST_ITEM   = 4 + 23 * (TERMS - 1);
  localparam int DRAIN_CYCLES   = SLOWEST_ITEM + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int N_RANDOM       = 380;
  localparam int N_DIRECTED     = 21;
  localparam int ONE_Q30        = 1 << 30;

  typedef struct {
    logic                        cmd;
    logic signed [ANGLE_W-1:0]   angle;
    bit                          known;
    logic signed [VALUE_W-1:0]   value;
  } dir_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_cmd;
  logic signed [ANGLE_W-1:0]   in_angle;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [VALUE_W-1:0]   out_value;

  // Typed-in result for the beat on offer; travels with the payload.
  bit                          item_known;
  logic signed [VALUE_W-1:0]   item_value;

  logic signed [VALUE_W-1:0]   series_results[$];
  logic signed [VALUE_W-1:0]   want;
  dir_row_t                    dir_rows [N_DIRECTED];
  int                          errors;
  int                          stall_cycles;
  bit                          rx_hold_req;
  bit                          no_idle;

  sine_cosine_taylor_series_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Maclaurin sum in fixed point: Q3.28 angle in, Q2.30 result out.
  function automatic logic signed [VALUE_W-1:0] series_sum(
    input logic cmd, input logic signed [ANGLE_W-1:0] angle);
    longint          ang;
    longint          sum;
    longint unsigned mag_a;
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    logic            neg;
    int              k;
    ang = longint'(angle);
    if (ang > ANGLE_MAX) ang = longint'(ANGLE_MAX);
    if (ang < ANGLE_MIN) ang = longint'(ANGLE_MIN);
    neg = ang < 0;
    mag_a = neg ? -ang : ang;
    x2 = (mag_a * mag_a + (64'd1 << RND_BIT)) >> FRAC_SHIFT;
    if (cmd == CMD_COSINE) begin
      mag = 64'(Q30_ONE);
      neg = 1'b0;
    end else begin
      mag = mag_a << 2;
    end
    sum = neg ? -longint'(mag) : longint'(mag);
    for (k = 1; k < TERMS; k++) begin
      n = (cmd == CMD_COSINE) ? longint'(2 * k - 1) : longint'(2 * k);
      d = n * (n + 1);
      q = (mag * x2) / d;
      mag = (q + (64'd1 << RND_BIT)) >> FRAC_SHIFT;
      neg = !neg;
      if (mag == 0) break;
      sum += neg ? -longint'(mag) : longint'(mag);
    end
    if (sum > ONE_Q30) sum = longint'(ONE_Q30);
    if (sum < -ONE_Q30) sum = -longint'(ONE_Q30);
    return VALUE_W'(sum);
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int unsigned r;
    int          lim;
    int          v;
    r   = $urandom_range(99);
    lim = int'(ANGLE_MAX);
    if (r < 35) begin
      v = int'($urandom_range(1 << 20)) - (1 << 19);
    end else if (r < 75) begin
      v = int'($urandom_range(2 * lim)) - lim;
    end else if (r < 88) begin
      v = int'($urandom);
    end else begin
      v = lim + int'($urandom_range(6)) - 3;
      if ($urandom_range(1)) v = -v;
    end
    return ANGLE_W'(v);
  endfunction

  // Offer one beat and hold it until accepted, then idle a while unless the gap is zero.
  task automatic send_item(input logic cmd, input logic signed [ANGLE_W-1:0] angle,
                           input bit known, input logic signed [VALUE_W-1:0] value);
    int unsigned gap;
    in_cmd     <= cmd;
    in_angle   <= angle;
    item_known <= known;
    item_value <= value;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Scoreboard and watchdog share the edge so push and pop keep beat order.
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      series_results.push_back(item_known ? item_value : series_sum(in_cmd, in_angle));
    end
    if (out_valid && out_ready) begin
      if (series_results.size() == 0) begin
        $error("out beat with nothing pending: value %0d", out_value);
        errors++;
      end else begin
        want = series_results.pop_front();
        if (out_value !== want) begin
          $error("value mismatch: expected %0d, actual %0d", want, out_value);
          errors++;
        end
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    int unsigned run;
    int unsigned gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      run = no_idle ? 50 : $urandom_range(12, 1);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = no_idle ? 0 : idle_len();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned i;
    errors       = 0;
    stall_cycles = 0;
    rx_hold_req  = 1'b0;
    no_idle      = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_cmd     <= CMD_SINE;
    in_angle   <= '0;
    item_known <= 1'b0;
    item_value <= '0;
    dir_rows = '{
      '{CMD_SINE,   31'sd0,          1'b1, 32'sd0},
      '{CMD_COSINE, 31'sd0,          1'b1, 32'sd1073741824},
      '{CMD_SINE,   31'sd1,          1'b1, 32'sd4},
      '{CMD_SINE,   -31'sd1,         1'b1, -32'sd4},
      '{CMD_COSINE, 31'sd1,          1'b1, 32'sd1073741824},
      '{CMD_COSINE, -31'sd1,         1'b1, 32'sd1073741824},
      '{CMD_SINE,   ANGLE_MAX,       1'b0, 32'sd0},
      '{CMD_SINE,   ANGLE_MIN,       1'b0, 32'sd0},
      '{CMD_COSINE, ANGLE_MAX,       1'b0, 32'sd0},
      '{CMD_COSINE, ANGLE_MIN,       1'b0, 32'sd0},
      '{CMD_SINE,   31'h3FFFFFFF,    1'b0, 32'sd0},
      '{CMD_SINE,   31'h40000000,    1'b0, 32'sd0},
      '{CMD_COSINE, 31'h3FFFFFFF,    1'b0, 32'sd0},
      '{CMD_COSINE, 31'h40000000,    1'b0, 32'sd0},
      '{CMD_SINE,   31'sd421657428,  1'b0, 32'sd0},
      '{CMD_SINE,   -31'sd421657428, 1'b0, 32'sd0},
      '{CMD_COSINE, 31'sd421657428,  1'b0, 32'sd0},
      '{CMD_SINE,   31'h2AAAAAAA,    1'b0, 32'sd0},
      '{CMD_COSINE, 31'h55555555,    1'b0, 32'sd0},
      '{CMD_COSINE, 31'sd843314856,  1'b0, 32'sd0},
      '{CMD_SINE,   31'sd843314858,  1'b0, 32'sd0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      send_item(dir_rows[i].cmd, dir_rows[i].angle, dir_rows[i].known, dir_rows[i].value);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 60) begin
        // Drain the block completely before going on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (series_results.size() != 0) @(posedge clk);
      end
      if (i == 120) rx_hold_req = 1'b1;
      if (i == 250) no_idle = 1'b1;
      if (i == 300) no_idle = 1'b0;
      send_item(1'($urandom_range(1)), random_angle(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (series_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sct_pkg.sv
hdl/sct_div.sv
hdl/sine_cosine_taylor_series_top.sv
tb/sine_cosine_taylor_series_top_tb.sv
